FILE: design/assert_macros.svh
// assertion macros used by the checker file tun_check.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, quiet while reset is high
`define TUN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that is also checked across reset
`define TUN_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// beat types and constants for the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int CoordW  = 16;
  localparam int NormW   = 16;
  localparam int RootW   = 15;                 // result magnitude 0..16384
  localparam int SearchN = RootW;              // one result bit per stage
  localparam int MagW    = 34;                 // |cross component|
  localparam int SumW    = 68;                 // sum of three squares
  localparam int SqW     = 2 * MagW;
  localparam int AccW    = 101;                // signed search accumulators
  localparam int RhsW    = SqW + 30;           // a^2 * 2^30

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } in_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic                       deg;
    logic [SumW-1:0]            s;
    logic [2:0]                 neg;
    logic [2:0][RhsW-1:0]       a2;
    logic [2:0][AccW-1:0]       p;
    logic [2:0][AccW-1:0]       q;
    logic [2:0][RootW-1:0]      r;
  } srch_t;

endpackage

FILE: design/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit normal of a triangle, Q8.8 vertices in, Q1.14 normal out
// ----------------------------------------------------------------------------
//   channel | signals                      | beat
//   in      | in_valid, in_ready, in_data  | three vertices, signed Q8.8
//   out     | out_valid, out_ready, out_data | normal in Q1.14 + degenerate
//
// one beat per cycle sustained while the output is not stalled; the stages are 5
// front stages, one seed register, 15 root search stages and one output register
// the whole pipe advances on one enable: it moves when the output register
// is empty or being taken, so a stalled output holds every stage in place
// reset clears the valid bits only; the data registers carry no reset
module triangle_unit_normal (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tun_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output tun_pkg::out_t out_data
);
  import tun_pkg::*;

  localparam int Depth = 6 + SearchN;

  logic adv;
  logic [Depth-1:0] vld;

  // front stage registers
  logic signed [CoordW:0]    e1 [3];
  logic signed [CoordW:0]    e2 [3];
  logic signed [2*CoordW+1:0] pr [6];
  logic signed [MagW:0]      cr [3];
  logic [MagW-1:0]           mag [3];
  logic [2:0]                neg_c, neg_d;
  logic [SqW-1:0]            sq [3];
  srch_t                     seed;
  srch_t                     st [1:SearchN];

  // whole pipe moves when the output slot frees up
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[Depth-2:0], in_valid};
      out_valid <= vld[Depth-1];
    end
  end

  // edge differences
  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= 17'(in_data.v0_x) - 17'(in_data.v1_x);
      e1[1] <= 17'(in_data.v0_y) - 17'(in_data.v1_y);
      e1[2] <= 17'(in_data.v0_z) - 17'(in_data.v1_z);
      e2[0] <= 17'(in_data.v1_x) - 17'(in_data.v2_x);
      e2[1] <= 17'(in_data.v1_y) - 17'(in_data.v2_y);
      e2[2] <= 17'(in_data.v1_z) - 17'(in_data.v2_z);
    end
  end

  // six partial products of the cross product
  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
    end
  end

  // cross components
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        cr[j] <= (MagW+1)'(pr[2*j]) - (MagW+1)'(pr[2*j+1]);
      end
    end
  end

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        mag[j]   <= cr[j][MagW] ? MagW'(-cr[j]) : MagW'(cr[j]);
        neg_c[j] <= cr[j][MagW];
      end
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sq[j] <= mag[j] * mag[j];
      end
      neg_d <= neg_c;
    end
  end

  // squared length and search seed: p = s*t^2, q = s*t with t = 2r-1, r = 0
  always_comb begin
    logic [SumW-1:0] s;
    s = SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
    seed.deg = (s == '0);
    seed.s   = s;
    seed.neg = neg_d;
    for (int j = 0; j < 3; j++) begin
      seed.a2[j] = {sq[j], 30'd0};
      seed.p[j]  = AccW'(s);
      seed.q[j]  = -AccW'(s);
      seed.r[j]  = '0;
    end
  end

  // root search: one result bit per stage, shift-and-add updates of p and q
  for (genvar g = 0; g < SearchN; g++) begin : g_srch
    localparam int K = SearchN - 1 - g;
    srch_t cur, nxt;

    if (g == 0) begin : g_seed
      always_ff @(posedge clk) begin
        if (adv) cur <= seed;
      end
    end else begin : g_chain
      assign cur = st[g];
    end

    always_comb begin
      logic signed [AccW-1:0] sx, cand, rhs;
      sx  = $signed(AccW'(cur.s));
      nxt = cur;
      for (int j = 0; j < 3; j++) begin
        cand = $signed(cur.p[j]) + ($signed(cur.q[j]) <<< (K + 2)) + (sx <<< (2*K + 2));
        rhs  = $signed(AccW'(cur.a2[j]));
        if (cand <= rhs) begin
          nxt.p[j]    = cand;
          nxt.q[j]    = $signed(cur.q[j]) + (sx <<< (K + 1));
          nxt.r[j][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) st[g+1] <= nxt;
    end
  end

  // sign, degenerate override, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.degenerate <= st[SearchN].deg;
      if (st[SearchN].deg) begin
        out_data.normal_x <= '0;
        out_data.normal_y <= '0;
        out_data.normal_z <= '0;
      end else begin
        out_data.normal_x <= st[SearchN].neg[0] ? -NormW'(st[SearchN].r[0])
                                                 : NormW'(st[SearchN].r[0]);
        out_data.normal_y <= st[SearchN].neg[1] ? -NormW'(st[SearchN].r[1])
                                                 : NormW'(st[SearchN].r[1]);
        out_data.normal_z <= st[SearchN].neg[2] ? -NormW'(st[SearchN].r[2])
                                                 : NormW'(st[SearchN].r[2]);
      end
    end
  end

endmodule

FILE: design/tun_check.sv
// ----------------------------------------------------------------------------
// tun_check
// port-level checks for triangle_unit_normal, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tun_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input tun_pkg::out_t out_data
);
  import tun_pkg::*;

  `TUN_ASSERT_ANY(a_rst_empty, rst |=> !out_valid, "output beat right after reset")
  `TUN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output beat changed")
  `TUN_ASSERT(a_deg_zero, out_valid && out_data.degenerate |-> out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0, "degenerate beat with nonzero normal")
  `TUN_ASSERT(a_stall_back, out_valid && !out_ready |-> !in_ready, "input taken while pipe is stalled")

endmodule

bind triangle_unit_normal tun_check u_tun_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
